// File: design/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and held off in reset.
`define BNC_ASSERT_IMPL(name, clk, rst_n, lhs, rhs) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge and held off in reset.
`define BNC_ASSERT_NEXT(name, clk, rst_n, lhs, rhs) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// File: design/bnc_pkg.sv
// Shared codes, defaults and types of the normalized convolution block.
package bnc_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_KERNEL = 7;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_PIXEL = 2'd1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
    localparam logic [1:0] STATUS_ZERO_SUM = 2'd2;

    localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_KERNEL_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_KERNEL_HEIGHT = 2'd3;

    typedef struct packed {
        logic valid;
        logic neg;
    } div_ctl_t;

endpackage

// File: design/bnc_div_cell.sv
// One restoring-division cell: resolves one quotient bit and hands on to its neighbor.
module bnc_div_cell
    import bnc_pkg::*;
#(
    parameter int REM_W = 56,
    parameter int DEN_W = 23,
    parameter int Q_W   = 18,
    parameter int SHIFT = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctl_t         ctl_in,
    input  logic [REM_W-1:0] rem_in,
    input  logic [DEN_W-1:0] den_in,
    input  logic [Q_W-1:0]   quo_in,
    output div_ctl_t         ctl_out,
    output logic [REM_W-1:0] rem_out,
    output logic [DEN_W-1:0] den_out,
    output logic [Q_W-1:0]   quo_out
);

    logic [REM_W-1:0] den_shift;
    logic             fits;
    logic [REM_W-1:0] rem_next;
    logic [Q_W-1:0]   quo_next;
    div_ctl_t         ctl_reg;
    logic [REM_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   quo_reg;

    assign den_shift = REM_W'(den_in) << SHIFT;
    assign fits      = (rem_in >= den_shift);

    always_comb
    begin
        rem_next       = fits ? (rem_in - den_shift) : rem_in;
        quo_next       = quo_in;
        quo_next[SHIFT] = fits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_in;
        quo_reg <= quo_next;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;

endmodule

// File: design/border_normalized_convolution_2d_top.sv
// Top level of the border-normalized 2-D convolution block.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid / in_stall       func, coef_row, coef_col, coefficient, pixel
//   output    out        out_valid / out_stall     out_pixel, out_row, out_col, status, frame_last
//   config    in         cfg_we                    cfg_index, cfg_data
//
// A transaction that yields no result (coefficient load, pixel before the lag is reached,
// early flush) leaves the sequencer idle. One that yields a result steps the row base back over
// the top rows of the window, reads the R*C window cells inside the image through the single
// window read port of the line memory, then runs the 18-cell divider chain. Reset clears
// control state only; the memories hold nothing defined until written. The input stalls during
// a register write, and a finished result waits in the output register while the next is taken.
module border_normalized_convolution_2d_top
    import bnc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = DEF_MAX_KERNEL
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [2:0]         coef_row,
    input  logic [2:0]         coef_col,
    input  logic signed [15:0] coefficient,
    input  logic signed [15:0] pixel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] out_pixel,
    output logic [9:0]         out_row,
    output logic [9:0]         out_col,
    output logic [1:0]         status,
    output logic               frame_last
);

    localparam int LINE_DEPTH = MAX_KERNEL * MAX_WIDTH;
    localparam int LA_W       = $clog2(LINE_DEPTH);
    localparam int KDEPTH     = MAX_KERNEL * MAX_KERNEL;
    localparam int KA_W       = $clog2(KDEPTH);
    localparam int KI_W       = $clog2(MAX_KERNEL);
    localparam int CW         = $clog2(MAX_WIDTH + 1);
    localparam int RW         = $clog2(MAX_HEIGHT + 1);
    localparam int N_W        = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int LAG_W      = $clog2(LINE_DEPTH + 1);
    localparam int ACC_W      = 32 + $clog2(KDEPTH);
    localparam int WS_W       = 16 + $clog2(KDEPTH);
    localparam int DEN_W      = WS_W + 1;
    localparam int Q_W        = 18;
    localparam int REM_W      = ACC_W + Q_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_DRAIN,
        ST_DIV,
        ST_HOLD
    } st_t;

    function automatic logic [LA_W-1:0] ptr_add(input logic [LA_W-1:0] a,
                                                input logic [LA_W-1:0] b);
        logic [LA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (LA_W+1)'(LINE_DEPTH))
        begin
            s = s - (LA_W+1)'(LINE_DEPTH);
        end
        return s[LA_W-1:0];
    endfunction

    function automatic logic [LA_W-1:0] ptr_sub(input logic [LA_W-1:0] a,
                                                input logic [LA_W-1:0] b);
        logic [LA_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[LA_W])
        begin
            d = d + (LA_W+1)'(LINE_DEPTH);
        end
        return d[LA_W-1:0];
    endfunction

    // Control state.
    st_t             state_reg;
    logic [10:0]     img_w_reg;
    logic [10:0]     img_h_reg;
    logic [2:0]      ker_w_reg;
    logic [2:0]      ker_h_reg;
    logic [RW-1:0]   in_row_reg;
    logic [CW-1:0]   in_col_reg;
    logic [N_W-1:0]  nraw_reg;
    logic [LA_W-1:0] wr_ptr_reg;
    logic [RW-1:0]   out_row_reg;
    logic [CW-1:0]   out_col_reg;
    logic [LA_W-1:0] out_ptr_reg;
    logic            full_reg;
    logic            out_valid_reg;
    logic            rd_v_reg;
    logic            prod_v_reg;
    div_ctl_t        div_ctl_reg;
    logic [KI_W-1:0] prep_cnt_reg;
    logic [KI_W-1:0] row_left_reg;
    logic [KI_W-1:0] col_left_reg;
    logic [KI_W-1:0] ncols_reg;
    logic [KI_W-1:0] kr_reg;
    logic [KI_W-1:0] kc_reg;
    logic [KI_W-1:0] kc0_reg;
    logic [LA_W-1:0] rowbase_reg;
    logic [LA_W-1:0] la_reg;

    // Datapath registers.
    logic [15:0]              line_mem [LINE_DEPTH];
    logic [15:0]              kern_mem [KDEPTH];
    logic signed [15:0]       pix_reg;
    logic signed [15:0]       coef_reg;
    logic signed [31:0]       prod_reg;
    logic signed [15:0]       coef_d_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [WS_W-1:0]   ws_reg;
    logic [REM_W-1:0]         div_rem_reg;
    logic [DEN_W-1:0]         div_den_reg;
    logic                     ws_zero_reg;
    logic [9:0]               e_row_reg;
    logic [9:0]               e_col_reg;
    logic                     e_last_reg;
    logic signed [15:0]       res_reg;
    logic [1:0]               res_status_reg;
    logic signed [15:0]       o_pixel_reg;
    logic [9:0]               o_row_reg;
    logic [9:0]               o_col_reg;
    logic [1:0]               o_status_reg;
    logic                     o_last_reg;

    // Effective configuration.
    logic [CW-1:0]   w_eff;
    logic [RW-1:0]   h_eff;
    logic [KI_W-1:0] hkr;
    logic [KI_W-1:0] hkc;
    logic            kw_ok;
    logic            kh_ok;
    logic [LAG_W-1:0] lag;

    always_comb
    begin
        if (img_w_reg == 11'd0)
            w_eff = CW'(1);
        else if (32'(img_w_reg) > MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(img_w_reg);

        if (img_h_reg == 11'd0)
            h_eff = RW'(1);
        else if (32'(img_h_reg) > MAX_HEIGHT)
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(img_h_reg);

        hkr = (32'(ker_h_reg) > MAX_KERNEL) ? KI_W'(MAX_KERNEL / 2) : KI_W'(ker_h_reg >> 1);
        hkc = (32'(ker_w_reg) > MAX_KERNEL) ? KI_W'(MAX_KERNEL / 2) : KI_W'(ker_w_reg >> 1);
        kw_ok = (ker_w_reg != 3'd0) && (32'(ker_w_reg) <= MAX_KERNEL) && ker_w_reg[0];
        kh_ok = (ker_h_reg != 3'd0) && (32'(ker_h_reg) <= MAX_KERNEL) && ker_h_reg[0];
        lag = LAG_W'(32'(hkr) * 32'(w_eff) + 32'(hkc));
    end

    // Transaction decode.
    logic in_acc;
    logic pix_go;
    logic emit_go;
    logic kload_go;

    assign in_acc   = in_valid && !in_stall;
    assign kload_go = in_acc && (func == FUNC_LOAD) &&
                      (32'(coef_row) < MAX_KERNEL) && (32'(coef_col) < MAX_KERNEL);
    assign pix_go   = in_acc && (func == FUNC_PIXEL) && !full_reg;
    assign emit_go  = in_acc && ((pix_go && (32'(nraw_reg) >= 32'(lag))) ||
                                 ((func != FUNC_LOAD) && full_reg));

    // Window extent of the pixel about to be emitted.
    logic [31:0]     rows_below;
    logic [31:0]     cols_right;
    logic [KI_W-1:0] dt;
    logic [KI_W-1:0] db;
    logic [KI_W-1:0] dl;
    logic [KI_W-1:0] dr;
    logic            e_last;
    logic            frame_done;

    always_comb
    begin
        rows_below = 32'(h_eff) - 32'd1 - 32'(out_row_reg);
        cols_right = 32'(w_eff) - 32'd1 - 32'(out_col_reg);
        dt = (32'(out_row_reg) >= 32'(hkr)) ? hkr : KI_W'(out_row_reg);
        db = (rows_below >= 32'(hkr)) ? hkr : KI_W'(rows_below);
        dl = (32'(out_col_reg) >= 32'(hkc)) ? hkc : KI_W'(out_col_reg);
        dr = (cols_right >= 32'(hkc)) ? hkc : KI_W'(cols_right);
        e_last = (rows_below == 32'd0) && (cols_right == 32'd0);
    end

    // The final output of a frame restarts all counters, the input side included.
    assign frame_done = emit_go && e_last;

    // The divider is a chain of cells of one module, each with its own shift, one quotient bit per cell.
    div_ctl_t         ctl_w [Q_W+1];
    logic [REM_W-1:0] rem_w [Q_W+1];
    logic [DEN_W-1:0] den_w [Q_W+1];
    logic [Q_W-1:0]   quo_w [Q_W+1];

    assign ctl_w[0] = div_ctl_reg;
    assign rem_w[0] = div_rem_reg;
    assign den_w[0] = div_den_reg;
    assign quo_w[0] = '0;

    for (genvar g = 0; g < Q_W; g++)
    begin : g_cell
        bnc_div_cell #(
            .REM_W (REM_W),
            .DEN_W (DEN_W),
            .Q_W   (Q_W),
            .SHIFT (Q_W - 1 - g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_w[g]),
            .rem_in  (rem_w[g]),
            .den_in  (den_w[g]),
            .quo_in  (quo_w[g]),
            .ctl_out (ctl_w[g+1]),
            .rem_out (rem_w[g+1]),
            .den_out (den_w[g+1]),
            .quo_out (quo_w[g+1])
        );
    end

    // Rounding already folded into the dividend; here the quotient is signed and saturated.
    logic [Q_W-1:0]     q_fin;
    logic signed [15:0] q_sat;

    always_comb
    begin
        q_fin = quo_w[Q_W];
        if (ctl_w[Q_W].neg)
        begin
            q_sat = (q_fin > Q_W'(32768)) ? 16'sh8000 : 16'(-q_fin);
        end
        else
        begin
            q_sat = (q_fin > Q_W'(32767)) ? 16'sh7FFF : 16'(q_fin);
        end
    end

    logic                    run_launch;
    logic [ACC_W-1:0]        acc_abs;
    logic [WS_W-1:0]         ws_abs;

    assign run_launch = (state_reg == ST_DRAIN) && !rd_v_reg && !prod_v_reg;
    assign acc_abs    = acc_reg[ACC_W-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
    assign ws_abs     = ws_reg[WS_W-1] ? $unsigned(-ws_reg) : $unsigned(ws_reg);

    // Sequencer and frame bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            img_w_reg     <= 11'd1024;
            img_h_reg     <= 11'd1024;
            ker_w_reg     <= 3'd3;
            ker_h_reg     <= 3'd3;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            nraw_reg      <= '0;
            wr_ptr_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_ptr_reg   <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            div_ctl_reg   <= '0;
            prep_cnt_reg  <= '0;
            row_left_reg  <= '0;
            col_left_reg  <= '0;
            ncols_reg     <= '0;
            kr_reg        <= '0;
            kc_reg        <= '0;
            kc0_reg       <= '0;
            rowbase_reg   <= '0;
            la_reg        <= '0;
        end
        else
        begin
            rd_v_reg          <= (state_reg == ST_RUN);
            prod_v_reg        <= rd_v_reg;
            div_ctl_reg.valid <= run_launch;
            div_ctl_reg.neg   <= acc_reg[ACC_W-1] ^ ws_reg[WS_W-1];

            if ((state_reg == ST_HOLD) && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_IMAGE_WIDTH:   img_w_reg <= cfg_data;
                    CFG_IMAGE_HEIGHT:  img_h_reg <= cfg_data;
                    CFG_KERNEL_WIDTH:  ker_w_reg <= cfg_data[2:0];
                    CFG_KERNEL_HEIGHT: ker_h_reg <= cfg_data[2:0];
                endcase
                in_row_reg  <= '0;
                in_col_reg  <= '0;
                nraw_reg    <= '0;
                wr_ptr_reg  <= '0;
                out_row_reg <= '0;
                out_col_reg <= '0;
                out_ptr_reg <= '0;
                full_reg    <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pix_go && !frame_done)
                    begin
                        if (32'(in_col_reg) + 32'd1 >= 32'(w_eff))
                        begin
                            in_col_reg <= '0;
                            if (32'(in_row_reg) + 32'd1 >= 32'(h_eff))
                            begin
                                in_row_reg <= '0;
                                full_reg   <= 1'b1;
                                nraw_reg   <= '0;
                                wr_ptr_reg <= '0;
                            end
                            else
                            begin
                                in_row_reg <= in_row_reg + 1'b1;
                                nraw_reg   <= nraw_reg + 1'b1;
                                wr_ptr_reg <= ptr_add(wr_ptr_reg, LA_W'(1));
                            end
                        end
                        else
                        begin
                            in_col_reg <= in_col_reg + 1'b1;
                            nraw_reg   <= nraw_reg + 1'b1;
                            wr_ptr_reg <= ptr_add(wr_ptr_reg, LA_W'(1));
                        end
                    end

                    if (emit_go)
                    begin
                        if (frame_done)
                        begin
                            // Frame complete: everything starts over.
                            out_col_reg <= '0;
                            out_row_reg <= '0;
                            out_ptr_reg <= '0;
                            in_row_reg  <= '0;
                            in_col_reg  <= '0;
                            nraw_reg    <= '0;
                            wr_ptr_reg  <= '0;
                            full_reg    <= 1'b0;
                        end
                        else if (32'(out_col_reg) + 32'd1 >= 32'(w_eff))
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + 1'b1;
                            out_ptr_reg <= ptr_add(out_ptr_reg, LA_W'(1));
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + 1'b1;
                            out_ptr_reg <= ptr_add(out_ptr_reg, LA_W'(1));
                        end

                        rowbase_reg  <= ptr_sub(out_ptr_reg, LA_W'(dl));
                        prep_cnt_reg <= dt;
                        row_left_reg <= dt + db;
                        col_left_reg <= dl + dr;
                        ncols_reg    <= dl + dr;
                        kr_reg       <= hkr + dt;
                        kc_reg       <= hkc - dl;
                        kc0_reg      <= hkc - dl;
                        state_reg    <= (kw_ok && kh_ok) ? ST_PREP : ST_HOLD;
                    end
                end

                ST_PREP:
                begin
                    // Step the row base back to the top row of the window.
                    if (prep_cnt_reg == '0)
                    begin
                        la_reg    <= rowbase_reg;
                        state_reg <= ST_RUN;
                    end
                    else
                    begin
                        rowbase_reg  <= ptr_sub(rowbase_reg, LA_W'(w_eff));
                        prep_cnt_reg <= prep_cnt_reg - 1'b1;
                    end
                end

                ST_RUN:
                begin
                    if (col_left_reg == '0)
                    begin
                        if (row_left_reg == '0)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        else
                        begin
                            row_left_reg <= row_left_reg - 1'b1;
                            rowbase_reg  <= ptr_add(rowbase_reg, LA_W'(w_eff));
                            la_reg       <= ptr_add(rowbase_reg, LA_W'(w_eff));
                            kr_reg       <= kr_reg - 1'b1;
                            kc_reg       <= kc0_reg;
                            col_left_reg <= ncols_reg;
                        end
                    end
                    else
                    begin
                        col_left_reg <= col_left_reg - 1'b1;
                        la_reg       <= ptr_add(la_reg, LA_W'(1));
                        kc_reg       <= kc_reg + 1'b1;
                    end
                end

                ST_DRAIN:
                begin
                    if (run_launch)
                    begin
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    if (ctl_w[Q_W].valid)
                    begin
                        state_reg <= ST_HOLD;
                    end
                end

                ST_HOLD:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Memories: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (pix_go)
        begin
            line_mem[wr_ptr_reg] <= pixel;
        end
        if (kload_go)
        begin
            kern_mem[KA_W'(32'(coef_row) * MAX_KERNEL + 32'(coef_col))] <= coefficient;
        end
        pix_reg  <= line_mem[la_reg];
        coef_reg <= kern_mem[KA_W'(32'(kr_reg) * MAX_KERNEL + 32'(kc_reg))];
    end

    // Multiply, accumulate, launch and result formatting.
    always_ff @(posedge clk)
    begin
        prod_reg   <= pix_reg * coef_reg;
        coef_d_reg <= coef_reg;

        if (emit_go)
        begin
            acc_reg        <= '0;
            ws_reg         <= '0;
            e_row_reg      <= 10'(out_row_reg);
            e_col_reg      <= 10'(out_col_reg);
            e_last_reg     <= e_last;
            res_reg        <= '0;
            res_status_reg <= STATUS_BAD_SIZE;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
            ws_reg  <= ws_reg + WS_W'(coef_d_reg);
        end

        if (run_launch)
        begin
            div_rem_reg <= REM_W'({acc_abs, 1'b0}) + REM_W'(ws_abs);
            div_den_reg <= {ws_abs, 1'b0};
            ws_zero_reg <= (ws_reg == '0);
        end

        if ((state_reg == ST_DIV) && ctl_w[Q_W].valid)
        begin
            res_reg        <= ws_zero_reg ? 16'sd0 : q_sat;
            res_status_reg <= ws_zero_reg ? STATUS_ZERO_SUM : STATUS_OK;
        end

        if ((state_reg == ST_HOLD) && (!out_valid_reg || !out_stall))
        begin
            o_pixel_reg  <= res_reg;
            o_row_reg    <= e_row_reg;
            o_col_reg    <= e_col_reg;
            o_status_reg <= res_status_reg;
            o_last_reg   <= e_last_reg;
        end
    end

    // The input waits while a result is in the making and during a register write.
    assign in_stall   = (state_reg != ST_IDLE) || cfg_we;
    assign out_valid  = out_valid_reg;
    assign out_pixel  = o_pixel_reg;
    assign out_row    = o_row_reg;
    assign out_col    = o_col_reg;
    assign status     = o_status_reg;
    assign frame_last = o_last_reg;

endmodule

// File: design/bnc_checker.sv
// Port-level checker for the normalized convolution block, with its bind.
`include "assert_macros.svh"

module bnc_checker
    import bnc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] out_pixel,
    input logic [1:0]         status
);

    `BNC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `BNC_ASSERT_IMPL(a_bad_zero, clk, rst_n, out_valid && (status == STATUS_BAD_SIZE), out_pixel == 16'sd0)
    `BNC_ASSERT_IMPL(a_sum_zero, clk, rst_n, out_valid && (status == STATUS_ZERO_SUM), out_pixel == 16'sd0)
    `BNC_ASSERT_IMPL(a_rise_busy, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind border_normalized_convolution_2d_top bnc_checker u_bnc_checker (.*);
